FILE: rtl/stpd_pkg.sv
package stpd_pkg;

  // Largest data length that a packet may announce.
  localparam int unsigned MaxData = 32;
  localparam int unsigned AddrW   = $clog2(MaxData);

  // Sync string "snp".
  localparam logic [7:0] Sync0 = 8'h73;
  localparam logic [7:0] Sync1 = 8'h6E;
  localparam logic [7:0] Sync2 = 8'h70;

  // Sum of the three sync bytes, the starting value of the checksum.
  localparam logic [15:0] SyncSum = 16'h0151;

  // Result kinds, carried on tuser.
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BAD_LEN = 2'd2,
    KIND_BAD_SUM = 2'd3
  } kind_e;

  // Receive phases of the parser.
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4
  } phase_e;

  // States of the emitter that plays a good packet out of the data memory.
  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_READ = 2'd1,
    EM_WAIT = 2'd2
  } emit_state_e;

  // Request from the parser to the emitter, valid for one cycle.
  typedef struct packed {
    logic        report;
    logic        start;
    kind_e       kind;
    logic [7:0]  ptype;
    logic [7:0]  length;
  } parse_req_t;

  // Status from the emitter back to the parser.
  typedef struct packed {
    logic busy;
    logic full;
  } emit_status_t;

endpackage

FILE: rtl/stpd_ram.sv
module stpd_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 8,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  // One write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // One read port; the data register holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/stpd_parser.sv
module stpd_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,
  input  stpd_pkg::emit_status_t      status_i,
  output stpd_pkg::parse_req_t        req_o,
  output logic                        wr_en_o,
  output logic [stpd_pkg::AddrW-1:0]  wr_addr_o,
  output logic [7:0]                  wr_data_o
);

  stpd_pkg::phase_e phase_q, phase_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       len_q, len_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       high_q, high_d;

  logic        fire;
  logic [7:0]  b;
  logic [15:0] sum_add;
  logic [5:0]  cnt_inc;
  logic        may_report;

  assign b       = s_axis_tdata;
  assign fire    = s_axis_tvalid && s_axis_tready;
  assign sum_add = sum_q + {8'h00, b};
  assign cnt_inc = cnt_q + 6'd1;

  // Bytes that can cause a report need the output register free.
  assign may_report = (phase_q == stpd_pkg::PH_LEN) ||
                      ((phase_q == stpd_pkg::PH_SUM) && (cnt_q != 6'd0));
  assign s_axis_tready = !status_i.busy && !(status_i.full && may_report);

  // Next state of the receive sequence.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    type_d  = type_q;
    len_d   = len_q;
    sum_d   = sum_q;
    high_d  = high_q;
    if (fire) begin
      unique case (phase_q)
        stpd_pkg::PH_TYPE: begin
          type_d  = b;
          sum_d   = sum_add;
          phase_d = stpd_pkg::PH_LEN;
        end
        stpd_pkg::PH_LEN: begin
          len_d = b;
          sum_d = sum_add;
          cnt_d = 6'd0;
          if (b > 8'(stpd_pkg::MaxData)) begin
            phase_d = stpd_pkg::PH_HUNT;
          end else if (b == 8'd0) begin
            phase_d = stpd_pkg::PH_SUM;
          end else begin
            phase_d = stpd_pkg::PH_DATA;
          end
        end
        stpd_pkg::PH_DATA: begin
          sum_d = sum_add;
          cnt_d = cnt_inc;
          if ({2'b00, cnt_inc} >= len_q) begin
            cnt_d   = 6'd0;
            phase_d = stpd_pkg::PH_SUM;
          end
        end
        stpd_pkg::PH_SUM: begin
          if (cnt_q == 6'd0) begin
            high_d = b;
            cnt_d  = 6'd1;
          end else begin
            cnt_d   = 6'd0;
            phase_d = stpd_pkg::PH_HUNT;
          end
        end
        default: begin
          // Hunting; a mismatching byte is not retested as the first sync byte.
          phase_d = stpd_pkg::PH_HUNT;
          if (cnt_q == 6'd0) begin
            cnt_d = (b == stpd_pkg::Sync0) ? 6'd1 : 6'd0;
          end else if (cnt_q == 6'd1) begin
            cnt_d = (b == stpd_pkg::Sync1) ? 6'd2 : 6'd0;
          end else if ((cnt_q == 6'd2) && (b == stpd_pkg::Sync2)) begin
            cnt_d   = 6'd0;
            sum_d   = stpd_pkg::SyncSum;
            phase_d = stpd_pkg::PH_TYPE;
          end else begin
            cnt_d = 6'd0;
          end
        end
      endcase
    end
  end

  // Requests to the emitter and writes to the data memory.
  always_comb begin
    req_o.report = 1'b0;
    req_o.start  = 1'b0;
    req_o.kind   = stpd_pkg::KIND_DATA;
    req_o.ptype  = type_q;
    req_o.length = len_q;
    wr_en_o      = fire && (phase_q == stpd_pkg::PH_DATA);
    wr_addr_o    = cnt_q[stpd_pkg::AddrW-1:0];
    wr_data_o    = b;
    if (fire && (phase_q == stpd_pkg::PH_LEN) && (b > 8'(stpd_pkg::MaxData))) begin
      req_o.report = 1'b1;
      req_o.kind   = stpd_pkg::KIND_BAD_LEN;
      req_o.length = b;
    end else if (fire && (phase_q == stpd_pkg::PH_SUM) && (cnt_q != 6'd0)) begin
      if ({high_q, b} != sum_q) begin
        req_o.report = 1'b1;
        req_o.kind   = stpd_pkg::KIND_BAD_SUM;
      end else if (len_q == 8'd0) begin
        req_o.report = 1'b1;
        req_o.kind   = stpd_pkg::KIND_EMPTY;
      end else begin
        req_o.start = 1'b1;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= stpd_pkg::PH_HUNT;
      cnt_q   <= 6'd0;
      type_q  <= 8'd0;
      len_q   <= 8'd0;
      sum_q   <= 16'd0;
      high_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      type_q  <= type_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      high_q  <= high_d;
    end
  end

endmodule

FILE: rtl/stpd_emitter.sv
module stpd_emitter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stpd_pkg::parse_req_t        req_i,
  output stpd_pkg::emit_status_t      status_o,
  output logic                        rd_en_o,
  output logic [stpd_pkg::AddrW-1:0]  rd_addr_o,
  input  logic [7:0]                  rd_data_i,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,
  output logic [1:0]                  m_axis_tuser,
  output logic                        m_axis_tlast
);

  stpd_pkg::emit_state_e state_q, state_d;
  logic [stpd_pkg::AddrW-1:0] idx_q, idx_d;
  logic [7:0]                 type_q, type_d;
  logic [7:0]                 len_q, len_d;

  logic                       out_valid_q, out_valid_d;
  stpd_pkg::kind_e            out_kind_q, out_kind_d;
  logic [7:0]                 out_type_q, out_type_d;
  logic [7:0]                 out_len_q, out_len_d;
  logic [7:0]                 out_data_q, out_data_d;
  logic [stpd_pkg::AddrW-1:0] out_idx_q, out_idx_d;
  logic                       out_last_q, out_last_d;

  logic out_free;
  logic is_final;
  logic load;

  assign out_free = !out_valid_q || m_axis_tready;
  assign is_final = ({{(8 - stpd_pkg::AddrW){1'b0}}, idx_q} + 8'd1) == len_q;
  assign load     = (state_q == stpd_pkg::EM_WAIT) && out_free;

  // Next state of the read-out sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stpd_pkg::EM_IDLE: if (req_i.start) state_d = stpd_pkg::EM_READ;
      stpd_pkg::EM_READ: state_d = stpd_pkg::EM_WAIT;
      stpd_pkg::EM_WAIT: begin
        if (out_free) begin
          state_d = is_final ? stpd_pkg::EM_IDLE : stpd_pkg::EM_READ;
        end
      end
      default: state_d = stpd_pkg::EM_IDLE;
    endcase
  end

  // Read address, packet header and output register contents.
  always_comb begin
    idx_d       = idx_q;
    type_d      = type_q;
    len_d       = len_q;
    rd_en_o     = (state_q == stpd_pkg::EM_READ);
    rd_addr_o   = idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_type_d  = out_type_q;
    out_len_d   = out_len_q;
    out_data_d  = out_data_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    if (req_i.start) begin
      idx_d  = '0;
      type_d = req_i.ptype;
      len_d  = req_i.length;
    end
    if (req_i.report) begin
      out_valid_d = 1'b1;
      out_kind_d  = req_i.kind;
      out_type_d  = req_i.ptype;
      out_len_d   = req_i.length;
      out_data_d  = 8'd0;
      out_idx_d   = '0;
      out_last_d  = 1'b1;
    end else if (load) begin
      out_valid_d = 1'b1;
      out_kind_d  = stpd_pkg::KIND_DATA;
      out_type_d  = type_q;
      out_len_d   = len_q;
      out_data_d  = rd_data_i;
      out_idx_d   = idx_q;
      out_last_d  = is_final;
      idx_d       = idx_q + stpd_pkg::AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stpd_pkg::EM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    type_q     <= type_d;
    len_q      <= len_d;
    out_kind_q <= out_kind_d;
    out_type_q <= out_type_d;
    out_len_q  <= out_len_d;
    out_data_q <= out_data_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign status_o.busy = (state_q != stpd_pkg::EM_IDLE);
  assign status_o.full = out_valid_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8 - stpd_pkg::AddrW){1'b0}}, out_idx_q, out_data_q,
                          out_len_q, out_type_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // The parser never issues a request while a packet is being played out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != stpd_pkg::EM_IDLE) |-> !(req_i.report || req_i.start))
    else $error("parser request during read-out");

  // A report never overwrites a word that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.report |-> out_free)
    else $error("report into a full output register");

  // The read index stays below the packet length while reading out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != stpd_pkg::EM_IDLE) |-> ({{(8 - stpd_pkg::AddrW){1'b0}}, idx_q} < len_q))
    else $error("read index beyond packet length");

  // Every report is a single, final word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q != stpd_pkg::KIND_DATA)) |-> out_last_q)
    else $error("report without last mark");
`endif

endmodule

FILE: rtl/sync_typed_packet_deframer.sv
// Packet deframer for a received byte stream. It hunts for the sync string
// "snp", then takes a type byte, a length byte, up to 32 data bytes and a
// big-endian 16-bit checksum equal to the wrapping sum of all bytes before
// it. Every byte is taken in one cycle while a packet is being received, save
// that the length byte and the last checksum byte wait while an earlier word
// is still untaken. The data bytes are kept in a 32 x 8 memory. After a good
// checksum the packet is played out of that memory one word at a time, each
// word a read of the memory and then a load into the output register, and the
// input is held off, through any stall on the output, until the last word is loaded.
// A bad length, a bad checksum or an empty good packet gives a single report
// word. No clearing is needed after reset.
module sync_typed_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // packet_type, length, data_byte, byte_index, zero fill
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last
);

  stpd_pkg::parse_req_t       req;
  stpd_pkg::emit_status_t     status;
  logic                       wr_en;
  logic [stpd_pkg::AddrW-1:0] wr_addr;
  logic [7:0]                 wr_data;
  logic                       rd_en;
  logic [stpd_pkg::AddrW-1:0] rd_addr;
  logic [7:0]                 rd_data;

  // Frame parsing and checksum.
  stpd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .status_i      (status),
    .req_o         (req),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data)
  );

  // Data byte store.
  stpd_ram #(
    .Depth (stpd_pkg::MaxData),
    .Width (8)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Read-out and output register.
  stpd_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .status_o      (status),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: tb/sync_typed_packet_deframer_test.sv
module sync_typed_packet_deframer_test;

  // Generous bound on the whole run, well above the slowest correct run.
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseBytes = 145;

  // One output word, in the field order of the stream.
  typedef struct packed {
    stpd_pkg::kind_e kind;
    logic [7:0]      ptype;
    logic [7:0]      len;
    logic [7:0]      dbyte;
    logic [4:0]      idx;
    logic            last;
  } deframed_word_t;

  // One row of directed stimulus; want is used only where typed is set.
  typedef struct packed {
    logic [7:0]     rx;
    logic           typed;
    deframed_word_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // packet_type, length, data_byte, byte_index, zero fill
  logic [1:0]  m_axis_tuser;          // kind
  logic        m_axis_tlast;          // last

  // Mirror of the deframer state.
  stpd_pkg::phase_e rx_phase = stpd_pkg::PH_HUNT;
  logic [5:0]       rx_count = '0;
  logic [7:0]       rx_type = '0;
  logic [7:0]       rx_len = '0;
  logic [7:0]       payload [stpd_pkg::MaxData];
  logic [15:0]      rx_sum = '0;
  logic [7:0]       sum_hi = '0;

  deframed_word_t expected_words [$];
  logic [7:0]     rx_plan [$];

  int send_idle_pct = 15;
  int recv_idle_pct = 82;
  int recv_hold_left = 0;
  int error_count = 0;
  int cycle_count = 0;

  // Directed bytes: the largest oversized length, a sync string broken
  // by a repeated 's' that must not be taken as a fresh start, an empty good
  // packet, and a one-byte packet with a wrong checksum.
  stim_row_t directed_rows [24] = '{
    '{8'h73, 1'b0, '0}, '{8'h6E, 1'b0, '0}, '{8'h70, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, '{stpd_pkg::KIND_BAD_LEN, 8'hFF, 8'hFF, 8'h00, 5'd0, 1'b1}},
    '{8'h73, 1'b0, '0}, '{8'h73, 1'b0, '0}, '{8'h6E, 1'b0, '0},
    '{8'h70, 1'b0, '0},
    '{8'h73, 1'b0, '0}, '{8'h6E, 1'b0, '0}, '{8'h70, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'h51, 1'b1, '{stpd_pkg::KIND_EMPTY, 8'h00, 8'h00, 8'h00, 5'd0, 1'b1}},
    '{8'h73, 1'b0, '0}, '{8'h6E, 1'b0, '0}, '{8'h70, 1'b0, '0},
    '{8'h7F, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'hAA, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{stpd_pkg::KIND_BAD_SUM, 8'h7F, 8'h01, 8'h00, 5'd0, 1'b1}}
  };

  sync_typed_packet_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Adds one expected word built from the held packet header.
  function automatic void note_word(input stpd_pkg::kind_e kind, input logic [7:0] dbyte,
                                    input logic [4:0] idx, input logic last);
    expected_words.push_back('{kind, rx_type, rx_len, dbyte, idx, last});
  endfunction

  // Advances the mirrored parser by one byte and queues the words it causes.
  function automatic int deframe_byte(input logic [7:0] b);
    int n = 0;
    case (rx_phase)
      stpd_pkg::PH_TYPE: begin
        rx_type = b;
        rx_sum = rx_sum + {8'h00, b};
        rx_phase = stpd_pkg::PH_LEN;
      end
      stpd_pkg::PH_LEN: begin
        rx_len = b;
        rx_sum = rx_sum + {8'h00, b};
        rx_count = '0;
        if (b > stpd_pkg::MaxData) begin
          note_word(stpd_pkg::KIND_BAD_LEN, 8'h00, 5'd0, 1'b1);
          n = 1;
          rx_phase = stpd_pkg::PH_HUNT;
        end else if (b == 8'h00) begin
          rx_phase = stpd_pkg::PH_SUM;
        end else begin
          rx_phase = stpd_pkg::PH_DATA;
        end
      end
      stpd_pkg::PH_DATA: begin
        if (rx_count < stpd_pkg::MaxData) payload[rx_count[4:0]] = b;
        rx_sum = rx_sum + {8'h00, b};
        rx_count = rx_count + 6'd1;
        if ({2'b00, rx_count} >= rx_len) begin
          rx_count = '0;
          rx_phase = stpd_pkg::PH_SUM;
        end
      end
      stpd_pkg::PH_SUM: begin
        if (rx_count == 6'd0) begin
          sum_hi = b;
          rx_count = 6'd1;
        end else begin
          if ({sum_hi, b} != rx_sum) begin
            note_word(stpd_pkg::KIND_BAD_SUM, 8'h00, 5'd0, 1'b1);
            n = 1;
          end else if (rx_len == 8'h00) begin
            note_word(stpd_pkg::KIND_EMPTY, 8'h00, 5'd0, 1'b1);
            n = 1;
          end else begin
            for (int i = 0; i < int'(rx_len) && i < stpd_pkg::MaxData; i++) begin
              note_word(stpd_pkg::KIND_DATA, payload[i], i[4:0], (i + 1 == int'(rx_len)));
              n++;
            end
          end
          rx_count = '0;
          rx_phase = stpd_pkg::PH_HUNT;
        end
      end
      default: begin
        // Sync hunt: a mismatching byte is not tried again as a first byte.
        rx_phase = stpd_pkg::PH_HUNT;
        if (rx_count == 6'd0) begin
          rx_count = (b == stpd_pkg::Sync0) ? 6'd1 : 6'd0;
        end else if (rx_count == 6'd1) begin
          rx_count = (b == stpd_pkg::Sync1) ? 6'd2 : 6'd0;
        end else if (rx_count == 6'd2 && b == stpd_pkg::Sync2) begin
          rx_count = '0;
          rx_sum = stpd_pkg::SyncSum;
          rx_phase = stpd_pkg::PH_TYPE;
        end else begin
          rx_count = '0;
        end
      end
    endcase
    return n;
  endfunction

  // Offers one byte, with random gaps, and predicts once it is taken.
  task automatic send_byte(input logic [7:0] rx, input logic typed,
                           input deframed_word_t want);
    int n;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rx;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    n = deframe_byte(rx);
    // A typed row replaces what the mirror predicted for this byte.
    if (typed) begin
      repeat (n) void'(expected_words.pop_back());
      expected_words.push_back(want);
    end
  endtask

  // Holds the input idle until every expected word has been seen.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Plans one framed packet; oversized lengths stop after the length byte.
  task automatic plan_packet(input int len, input logic corrupt);
    logic [15:0] sum;
    logic [7:0]  t;
    logic [7:0]  d;
    t = 8'($urandom);
    sum = stpd_pkg::SyncSum + {8'h00, t} + {8'h00, len[7:0]};
    rx_plan.push_back(stpd_pkg::Sync0);
    rx_plan.push_back(stpd_pkg::Sync1);
    rx_plan.push_back(stpd_pkg::Sync2);
    rx_plan.push_back(t);
    rx_plan.push_back(len[7:0]);
    if (len > stpd_pkg::MaxData) return;
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      sum = sum + {8'h00, d};
      rx_plan.push_back(d);
    end
    if (corrupt) sum = sum ^ (16'd1 << $urandom_range(15));
    rx_plan.push_back(sum[15:8]);
    rx_plan.push_back(sum[7:0]);
  endtask

  // One phase of random traffic: mostly well-formed packets, some noise and
  // some sync strings cut short.
  task automatic run_phase(input int s_idle, input int r_idle, input int hold);
    int r;
    int l;
    drain_results();
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    recv_hold_left = hold;
    if (hold > 0) plan_packet(stpd_pkg::MaxData, 1'b0);
    while (rx_plan.size() < PhaseBytes) begin
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) rx_plan.push_back(8'($urandom));
      end else if (r < 14) begin
        rx_plan.push_back(stpd_pkg::Sync0);
        if ($urandom_range(1)) rx_plan.push_back(stpd_pkg::Sync1);
        rx_plan.push_back(8'($urandom));
      end else begin
        l = $urandom_range(99);
        if (l < 6) l = 0;
        else if (l < 12) l = stpd_pkg::MaxData;
        else if (l < 15) l = stpd_pkg::MaxData + 1;
        else if (l < 20) l = $urandom_range(stpd_pkg::MaxData + 2, 255);
        else l = $urandom_range(1, 8);
        plan_packet(l, $urandom_range(99) < 15);
      end
    end
    while (rx_plan.size() != 0) send_byte(rx_plan.pop_front(), 1'b0, '0);
  endtask

  // Receiver: random stalls, or a long hold-off counted down here.
  initial begin
    forever begin
      @(negedge clk_i);
      if (recv_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        recv_hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted word with the oldest expectation.
  always @(posedge clk_i) begin
    deframed_word_t got;
    deframed_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{stpd_pkg::kind_e'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[15:8],
              m_axis_tdata[23:16], m_axis_tdata[28:24], m_axis_tlast};
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind %0d type %02h len %02h data %02h index %0d last %0b",
                 $time, got.kind, got.ptype, got.len, got.dbyte, got.idx, got.last);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t: word mismatch", $time);
          $display("  expected kind %0d type %02h len %02h data %02h index %0d last %0b",
                   want.kind, want.ptype, want.len, want.dbyte, want.idx, want.last);
          $display("  actual   kind %0d type %02h len %02h data %02h index %0d last %0b",
                   got.kind, got.ptype, got.len, got.dbyte, got.idx, got.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL sync_typed_packet_deframer");
      $finish;
    end
  end

  // Main sequence: reset, directed rows, then three phases of random traffic.
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    end
    run_phase(15, 82, 0);
    run_phase(82, 15, 0);
    // No random idling here, but the receiver first holds off long enough
    // for the block to stall its input behind a full-length packet.
    run_phase(0, 0, 400);
    drain_results();
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS sync_typed_packet_deframer");
    end else begin
      $display("FAIL sync_typed_packet_deframer");
    end
    $finish;
  end

endmodule
